// File: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file; empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define HCR_ASSERT_IMPLIES(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define HCR_ASSERT_NEXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);
`else
`define HCR_ASSERT_IMPLIES(lbl, a, b, msg)
`define HCR_ASSERT_NEXT(lbl, a, b, msg)
`endif
`endif

// File: hw/rtl/hcr_pkg.sv
// types, constants and name tables of the character reference decoder
`default_nettype none
package hcr_pkg;

	localparam int unsigned NAME_COUNT = 5;
	localparam logic [20:0] VALUE_MAX = 21'h10FFFF;
	localparam logic [15:0] REPLACEMENT = 16'hFFFD;
	localparam logic [15:0] SURR_LO = 16'hD800;
	localparam logic [15:0] SURR_HI = 16'hDFFF;
	localparam logic [15:0] LEAD_BASE = 16'hD800;
	localparam logic [15:0] TRAIL_BASE = 16'hDC00;
	localparam logic [20:0] SUPP_BASE = 21'h010000;

	// name lengths and decoded characters: amp, apos, gt, lt, quot
	localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{3'd3, 3'd4, 3'd2, 3'd2, 3'd4};
	localparam logic [15:0] NAME_CHAR [NAME_COUNT] =
		'{16'h0026, 16'h0027, 16'h003E, 16'h003C, 16'h0022};

	typedef enum logic [2:0] {
		PH_INITIAL   = 3'd0,
		PH_NUMERIC   = 3'd1,
		PH_MAYBE_HEX = 3'd2,
		PH_HEX       = 3'd3,
		PH_DECIMAL   = 3'd4,
		PH_NAMED     = 3'd5,
		PH_DONE      = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_PENDING = 2'd0,
		ST_DECODED = 2'd1,
		ST_REJECT  = 2'd2
	} status_t;

	typedef struct packed {
		phase_t      phase;
		logic [20:0] value;
		logic        invalid;
		logic [4:0]  cand;
		logic [2:0]  len;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:   PH_INITIAL,
		value:   21'd0,
		invalid: 1'b0,
		cand:    5'b11111,
		len:     3'd0
	};

	typedef struct packed {
		logic        is_digit;
		logic        is_alnum;
		logic        is_hex;
		logic        is_semi;
		logic        is_hash;
		logic        is_x;
		logic [3:0]  digit;
	} class_t;

	typedef struct packed {
		logic        done;
		logic        consumed;
		status_t     status;
		logic [1:0]  count;
		logic [15:0] first;
		logic [15:0] second;
	} res_t;

	// letter of a known name at a position, zero past its end
	function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case ({idx, pos})
			{3'd0, 3'd0}: ch = 8'h61;
			{3'd0, 3'd1}: ch = 8'h6D;
			{3'd0, 3'd2}: ch = 8'h70;
			{3'd1, 3'd0}: ch = 8'h61;
			{3'd1, 3'd1}: ch = 8'h70;
			{3'd1, 3'd2}: ch = 8'h6F;
			{3'd1, 3'd3}: ch = 8'h73;
			{3'd2, 3'd0}: ch = 8'h67;
			{3'd2, 3'd1}: ch = 8'h74;
			{3'd3, 3'd0}: ch = 8'h6C;
			{3'd3, 3'd1}: ch = 8'h74;
			{3'd4, 3'd0}: ch = 8'h71;
			{3'd4, 3'd1}: ch = 8'h75;
			{3'd4, 3'd2}: ch = 8'h6F;
			{3'd4, 3'd3}: ch = 8'h74;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/html_char_reference_decoder.sv
// top level of the html character reference decoder
`default_nettype none
`include "assert_macros.svh"
// Decodes one HTML character reference from the UTF-16 code units that follow an
// ampersand, one unit per request, with first_char set on the first unit. Each
// request gives exactly one result: pending, decoded (one unit or a surrogate
// pair, U+FFFD for zero, out-of-range, surrogate or unknown names) or not a
// reference with consumed low. The block takes one request every clock cycle
// while char_stall is low; a result is offered once its request has passed
// through an input register and a result register, and the parser state loop
// closes between them. A stalled result holds the pipeline, with the input
// register absorbing one further request.
module html_char_reference_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output logic             char_stall,
	input  wire logic [15:0] code_unit,
	input  wire logic        first_char,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             done_res,
	output logic             consumed,
	output logic [1:0]       status,
	output logic [1:0]       unit_count,
	output logic [15:0]      unit_first,
	output logic [15:0]      unit_second
);

	logic            valid_s1;
	logic [15:0]     code_unit_s1;
	logic            first_char_s1;
	logic            valid_s2;
	hcr_pkg::res_t   res_s2;
	hcr_pkg::state_t st_q;
	hcr_pkg::state_t st_nxt;
	hcr_pkg::res_t   res_nxt;
	hcr_pkg::class_t cls;
	logic            load_s2;
	logic            fire_s2;

	// result stage loads when empty or draining
	assign load_s2    = !valid_s2 || !res_stall;
	assign fire_s2    = valid_s1 && load_s2;
	assign char_stall = valid_s1 && !load_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			code_unit_s1  <= code_unit;
			first_char_s1 <= first_char;
		end
	end

	hcr_char_class u_class (
		.code_unit (code_unit_s1),
		.cls       (cls)
	);

	hcr_step u_step (
		.st_q       (st_q),
		.first_char (first_char_s1),
		.code_unit  (code_unit_s1),
		.cls        (cls),
		.st_nxt     (st_nxt),
		.res        (res_nxt)
	);

	// parser state, advanced once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= hcr_pkg::STATE_RESET;
		end else if (fire_s2) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s2) begin
			res_s2 <= res_nxt;
		end
	end

	assign res_valid   = valid_s2;
	assign done_res    = res_s2.done;
	assign consumed    = res_s2.consumed;
	assign status      = res_s2.status;
	assign unit_count  = res_s2.count;
	assign unit_first  = res_s2.first;
	assign unit_second = res_s2.second;

	// checks on the parser and pipeline
	`HCR_ASSERT_IMPLIES(a_decoded_done, res_valid && (status == hcr_pkg::ST_DECODED), done_res && consumed && (unit_count != 2'd0), "decoded result without done and consumed")
	`HCR_ASSERT_IMPLIES(a_pending_empty, res_valid && !done_res, (status == hcr_pkg::ST_PENDING) && consumed && (unit_count == 2'd0), "pending result carries data")
	`HCR_ASSERT_IMPLIES(a_pair_form, res_valid && (unit_count == 2'd2), (unit_first[15:10] == 6'b110110) && (unit_second[15:10] == 6'b110111), "malformed surrogate pair")
	`HCR_ASSERT_NEXT(a_stall_holds, char_stall, valid_s1, "input register lost a held request")

endmodule
`default_nettype wire

// File: hw/rtl/hcr_char_class.sv
// character classifier for one utf-16 code unit
`default_nettype none
module hcr_char_class (
	input  wire logic [15:0]    code_unit,
	output hcr_pkg::class_t     cls
);

	logic hi_zero;
	logic is_lower;
	logic is_upper;
	logic hex_lower;
	logic hex_upper;

	// range compares on the low byte, upper byte must be clear
	always_comb begin
		hi_zero   = (code_unit[15:8] == 8'h00);
		is_lower  = hi_zero && (code_unit[7:0] >= 8'h61) && (code_unit[7:0] <= 8'h7A);
		is_upper  = hi_zero && (code_unit[7:0] >= 8'h41) && (code_unit[7:0] <= 8'h5A);
		hex_lower = hi_zero && (code_unit[7:0] >= 8'h61) && (code_unit[7:0] <= 8'h66);
		hex_upper = hi_zero && (code_unit[7:0] >= 8'h41) && (code_unit[7:0] <= 8'h46);
		cls.is_digit = hi_zero && (code_unit[7:0] >= 8'h30) && (code_unit[7:0] <= 8'h39);
		cls.is_alnum = cls.is_digit || is_lower || is_upper;
		cls.is_hex   = cls.is_digit || hex_lower || hex_upper;
		cls.is_semi  = (code_unit == 16'h003B);
		cls.is_hash  = (code_unit == 16'h0023);
		cls.is_x     = (code_unit == 16'h0078) || (code_unit == 16'h0058);
		// '0' sits at 0x30, 'a' and 'A' at 0x1 in the low nibble
		cls.digit    = cls.is_digit ? code_unit[3:0] : code_unit[3:0] + 4'd9;
	end

endmodule
`default_nettype wire

// File: hw/rtl/hcr_step.sv
// parser step: next state and result for one code unit
`default_nettype none
module hcr_step (
	input  wire hcr_pkg::state_t st_q,
	input  wire logic            first_char,
	input  wire logic [15:0]     code_unit,
	input  wire hcr_pkg::class_t cls,
	output hcr_pkg::state_t      st_nxt,
	output hcr_pkg::res_t        res
);

	hcr_pkg::state_t st;
	hcr_pkg::state_t st_acc;
	hcr_pkg::state_t st_name;
	logic [24:0]     acc;
	logic            use_hex;
	logic            found;
	logic [15:0]     named_ch;
	logic [20:0]     supp;
	hcr_pkg::res_t   res_num;
	hcr_pkg::res_t   res_pend;
	hcr_pkg::res_t   res_rej;

	// first unit after the ampersand restarts the parser
	assign st = first_char ? hcr_pkg::STATE_RESET : st_q;

	// digit accumulate, times ten or sixteen
	assign use_hex = (st.phase == hcr_pkg::PH_MAYBE_HEX) || (st.phase == hcr_pkg::PH_HEX);
	always_comb begin
		if (use_hex) begin
			acc = {st.value, 4'b0000} + {21'd0, cls.digit};
		end else begin
			acc = {1'b0, st.value, 3'b000} + {3'b000, st.value, 1'b0} + {21'd0, cls.digit};
		end
		st_acc = st;
		if (!st.invalid) begin
			if (acc > {4'd0, hcr_pkg::VALUE_MAX}) begin
				st_acc.invalid = 1'b1;
				st_acc.value   = 21'd0;
			end else begin
				st_acc.value = acc[20:0];
			end
		end
	end

	// name letter: drop candidates that no longer match
	always_comb begin
		st_name = st;
		for (int i = 0; i < hcr_pkg::NAME_COUNT; i++) begin
			if ((st.len >= hcr_pkg::NAME_LEN[i]) ||
			    ({8'h00, hcr_pkg::name_char(3'(i), st.len)} != code_unit)) begin
				st_name.cand[i] = 1'b0;
			end
		end
		if (st.len != 3'd7) begin
			st_name.len = st.len + 3'd1;
		end
	end

	// named finish: first full-length surviving candidate
	always_comb begin
		found    = 1'b0;
		named_ch = hcr_pkg::REPLACEMENT;
		for (int i = 0; i < hcr_pkg::NAME_COUNT; i++) begin
			if (!found && st.cand[i] && (st.len == hcr_pkg::NAME_LEN[i])) begin
				named_ch = hcr_pkg::NAME_CHAR[i];
				found    = 1'b1;
			end
		end
	end

	// numeric finish with surrogate split
	assign supp = st.value - hcr_pkg::SUPP_BASE;
	always_comb begin
		res_num = '{done: 1'b1, consumed: 1'b1, status: hcr_pkg::ST_DECODED,
			count: 2'd1, first: hcr_pkg::REPLACEMENT, second: 16'd0};
		if (st.invalid || (st.value == 21'd0) ||
		    ((st.value >= {5'd0, hcr_pkg::SURR_LO}) && (st.value <= {5'd0, hcr_pkg::SURR_HI}))) begin
			res_num.first = hcr_pkg::REPLACEMENT;
		end else if (st.value[20:16] == 5'd0) begin
			res_num.first = st.value[15:0];
		end else begin
			res_num.count  = 2'd2;
			res_num.first  = hcr_pkg::LEAD_BASE + {6'd0, supp[19:10]};
			res_num.second = hcr_pkg::TRAIL_BASE + {6'd0, supp[9:0]};
		end
	end

	assign res_pend = '{done: 1'b0, consumed: 1'b1, status: hcr_pkg::ST_PENDING,
		count: 2'd0, first: 16'd0, second: 16'd0};
	assign res_rej = '{done: 1'b1, consumed: 1'b0, status: hcr_pkg::ST_REJECT,
		count: 2'd0, first: 16'd0, second: 16'd0};

	// phase decoder
	always_comb begin
		st_nxt = st;
		res    = res_rej;
		unique case (st.phase)
			hcr_pkg::PH_INITIAL: begin
				if (cls.is_hash) begin
					st_nxt.phase = hcr_pkg::PH_NUMERIC;
					res          = res_pend;
				end else if (cls.is_alnum) begin
					st_nxt       = st_name;
					st_nxt.phase = hcr_pkg::PH_NAMED;
					res          = res_pend;
				end else begin
					st_nxt.phase = hcr_pkg::PH_DONE;
				end
			end
			hcr_pkg::PH_NUMERIC: begin
				if (cls.is_x) begin
					st_nxt.phase = hcr_pkg::PH_MAYBE_HEX;
					res          = res_pend;
				end else if (cls.is_digit) begin
					st_nxt       = st_acc;
					st_nxt.phase = hcr_pkg::PH_DECIMAL;
					res          = res_pend;
				end else begin
					st_nxt.phase = hcr_pkg::PH_DONE;
				end
			end
			hcr_pkg::PH_MAYBE_HEX, hcr_pkg::PH_HEX: begin
				if (cls.is_hex) begin
					st_nxt       = st_acc;
					st_nxt.phase = hcr_pkg::PH_HEX;
					res          = res_pend;
				end else if (cls.is_semi && (st.phase == hcr_pkg::PH_HEX)) begin
					st_nxt.phase = hcr_pkg::PH_DONE;
					res          = res_num;
				end else begin
					st_nxt.phase = hcr_pkg::PH_DONE;
				end
			end
			hcr_pkg::PH_DECIMAL: begin
				if (cls.is_digit) begin
					st_nxt = st_acc;
					res    = res_pend;
				end else if (cls.is_semi) begin
					st_nxt.phase = hcr_pkg::PH_DONE;
					res          = res_num;
				end else begin
					st_nxt.phase = hcr_pkg::PH_DONE;
				end
			end
			hcr_pkg::PH_NAMED: begin
				if (cls.is_alnum) begin
					st_nxt = st_name;
					res    = res_pend;
				end else if (cls.is_semi) begin
					st_nxt.phase = hcr_pkg::PH_DONE;
					res          = '{done: 1'b1, consumed: 1'b1,
						status: hcr_pkg::ST_DECODED, count: 2'd1,
						first: named_ch, second: 16'd0};
				end else begin
					st_nxt.phase = hcr_pkg::PH_DONE;
				end
			end
			default: begin
				// finished: report the unit as outside the reference
				st_nxt = st;
				res    = res_rej;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the html character reference decoder
module tb;

	localparam int unsigned ITEM_GOAL = 525;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 8;
	localparam int unsigned CODE_LIMIT = 32'h0010FFFF;
	localparam int unsigned SURR_FIRST = 32'h0000D800;
	localparam int unsigned SURR_LAST = 32'h0000DFFF;
	localparam logic [15:0] REPL_UNIT = 16'hFFFD;
	localparam logic [15:0] LEAD_SURR = 16'hD800;
	localparam logic [15:0] TRAIL_SURR = 16'hDC00;
	localparam logic [15:0] CH_HASH = 16'h0023;
	localparam logic [15:0] CH_SEMI = 16'h003B;
	localparam logic [15:0] CH_ZERO = 16'h0030;
	localparam logic [15:0] CH_X_LOWER = 16'h0078;
	localparam logic [15:0] CH_X_UPPER = 16'h0058;

	typedef struct {
		logic [15:0] u;
		logic        s;
		logic        drain;
	} char_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic [15:0] code_unit = 16'h0000;
	logic        first_char = 1'b0;
	logic        res_stall = 1'b0;
	logic        char_stall;
	logic        res_valid;
	logic        done_res;
	logic        consumed;
	logic [1:0]  status;
	logic [1:0]  unit_count;
	logic [15:0] unit_first;
	logic [15:0] unit_second;

	char_req_t       pending_chars[$];
	hcr_pkg::res_t   expected_res[$];
	int unsigned     error_count = 0;
	int unsigned     item_total = 0;
	int unsigned     idle_cycles = 0;
	int unsigned     gap_left = 0;
	int unsigned     burst_left = 1;
	int unsigned     stall_pct = 0;
	int unsigned     stall_left = 0;
	bit              drain_next = 1'b0;

	// predicted parser state
	hcr_pkg::phase_t pr_phase;
	logic [20:0]     pr_value;
	logic            pr_invalid;
	logic [4:0]      pr_cand;
	logic [2:0]      pr_len;

	string       name_text [5] = '{"amp", "apos", "gt", "lt", "quot"};
	logic [15:0] name_unit [5] = '{16'h0026, 16'h0027, 16'h003E, 16'h003C, 16'h0022};
	string       alnum_set = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	html_char_reference_decoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.code_unit   (code_unit),
		.first_char  (first_char),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.done_res    (done_res),
		.consumed    (consumed),
		.status      (status),
		.unit_count  (unit_count),
		.unit_first  (unit_first),
		.unit_second (unit_second)
	);

	// character classes
	function automatic bit is_dec(input logic [15:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alnum(input logic [15:0] c);
		return is_dec(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_hexd(input logic [15:0] c);
		return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic int unsigned hex_value(input logic [15:0] c);
		if (is_dec(c))
			return c - CH_ZERO;
		if (c >= "a" && c <= "f")
			return c - "a" + 10;
		return c - "A" + 10;
	endfunction

	function automatic void clear_parser();
		pr_phase = hcr_pkg::PH_INITIAL;
		pr_value = '0;
		pr_invalid = 1'b0;
		pr_cand = 5'b11111;
		pr_len = 3'd0;
	endfunction

	// numeric accumulation, sticky invalid once past the last code point
	function automatic void accumulate(input int unsigned base, input int unsigned digit);
		int unsigned v;
		if (!pr_invalid) begin
			v = pr_value;
			v = v * base + digit;
			if (v > CODE_LIMIT) begin
				pr_invalid = 1'b1;
				pr_value = '0;
			end else begin
				pr_value = v[20:0];
			end
		end
	endfunction

	// drop every known name that does not have this letter here
	function automatic void take_letter(input logic [15:0] c);
		for (int i = 0; i < 5; i++) begin
			if (pr_len >= name_text[i].len() || name_text[i][pr_len] != c)
				pr_cand[i] = 1'b0;
		end
		if (pr_len < 3'd7)
			pr_len++;
	endfunction

	function automatic hcr_pkg::res_t finished(input logic [1:0] cnt, input logic [15:0] u1,
			input logic [15:0] u2);
		pr_phase = hcr_pkg::PH_DONE;
		return '{done: 1'b1, consumed: 1'b1, status: hcr_pkg::ST_DECODED, count: cnt,
			first: u1, second: u2};
	endfunction

	function automatic hcr_pkg::res_t rejected();
		pr_phase = hcr_pkg::PH_DONE;
		return '{done: 1'b1, consumed: 1'b0, status: hcr_pkg::ST_REJECT, count: 2'd0,
			first: 16'h0, second: 16'h0};
	endfunction

	// numeric character, replaced when zero, invalid or a surrogate
	function automatic hcr_pkg::res_t numeric_char();
		int unsigned v;
		v = pr_value;
		if (pr_invalid || v == 0 || (v >= SURR_FIRST && v <= SURR_LAST))
			return finished(2'd1, REPL_UNIT, 16'h0);
		if (v <= 32'hFFFF)
			return finished(2'd1, v[15:0], 16'h0);
		v = v - 32'h10000;
		return finished(2'd2, LEAD_SURR + v[19:10], TRAIL_SURR + v[9:0]);
	endfunction

	// expected result of one code unit, advances the predicted state
	function automatic hcr_pkg::res_t decode_unit(input logic [15:0] cu, input logic start);
		hcr_pkg::res_t r;
		r = '{done: 1'b0, consumed: 1'b1, status: hcr_pkg::ST_PENDING, count: 2'd0,
			first: 16'h0, second: 16'h0};
		if (start)
			clear_parser();
		case (pr_phase)
			hcr_pkg::PH_INITIAL: begin
				if (cu == CH_HASH) begin
					pr_phase = hcr_pkg::PH_NUMERIC;
				end else if (is_alnum(cu)) begin
					pr_phase = hcr_pkg::PH_NAMED;
					take_letter(cu);
				end else begin
					r = rejected();
				end
			end
			hcr_pkg::PH_NUMERIC: begin
				if (cu == CH_X_LOWER || cu == CH_X_UPPER) begin
					pr_phase = hcr_pkg::PH_MAYBE_HEX;
				end else if (is_dec(cu)) begin
					pr_phase = hcr_pkg::PH_DECIMAL;
					accumulate(10, cu - CH_ZERO);
				end else begin
					r = rejected();
				end
			end
			hcr_pkg::PH_MAYBE_HEX, hcr_pkg::PH_HEX: begin
				if (is_hexd(cu)) begin
					pr_phase = hcr_pkg::PH_HEX;
					accumulate(16, hex_value(cu));
				end else if (cu == CH_SEMI && pr_phase == hcr_pkg::PH_HEX) begin
					r = numeric_char();
				end else begin
					r = rejected();
				end
			end
			hcr_pkg::PH_DECIMAL: begin
				if (is_dec(cu))
					accumulate(10, cu - CH_ZERO);
				else if (cu == CH_SEMI)
					r = numeric_char();
				else
					r = rejected();
			end
			hcr_pkg::PH_NAMED: begin
				if (is_alnum(cu)) begin
					take_letter(cu);
				end else if (cu == CH_SEMI) begin
					r = finished(2'd1, REPL_UNIT, 16'h0);
					// first complete match wins
					for (int i = 4; i >= 0; i--) begin
						if (pr_cand[i] && pr_len == name_text[i].len())
							r.first = name_unit[i];
					end
				end else begin
					r = rejected();
				end
			end
			default: begin
				r = rejected();
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			error_count++;
		end
	endfunction

	// stimulus building
	task automatic add_unit(input logic [15:0] u, input logic s);
		pending_chars.push_back('{u: u, s: s, drain: drain_next && s});
		if (s)
			drain_next = 1'b0;
		item_total++;
	endtask

	task automatic add_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			add_unit({8'h00, txt[i]}, i == 0);
	endtask

	function automatic logic [15:0] odd_unit();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 16'hFFFF));
			1: return 16'h0020;
			2: return 16'h0026;
			default: return 16'($urandom_range(16'h21, 16'h7E));
		endcase
	endfunction

	// mostly ';', sometimes a stray unit, sometimes left open
	task automatic add_terminator();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 8)
			add_unit(CH_SEMI, 1'b0);
		else if (pick == 8)
			add_unit(odd_unit(), 1'b0);
	endtask

	task automatic add_number(input bit hex);
		int unsigned v;
		string digits;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = $urandom_range(1, 127);
			2: v = $urandom_range(SURR_FIRST, SURR_LAST);
			3: v = $urandom_range(1, 32'hFFFF);
			4: v = $urandom_range(32'h10000, CODE_LIMIT);
			5: v = CODE_LIMIT + $urandom_range(0, 1);
			6: v = $urandom();
			default: v = $urandom_range(1, CODE_LIMIT);
		endcase
		digits = hex ? $sformatf("%0h", v) : $sformatf("%0d", v);
		if ($urandom_range(0, 3) == 0)
			digits = {"00", digits};
		// broken form with no digits at all
		if ($urandom_range(0, 9) == 0)
			digits = "";
		add_unit(CH_HASH, 1'b1);
		if (hex)
			add_unit($urandom_range(0, 1) ? CH_X_UPPER : CH_X_LOWER, 1'b0);
		for (int i = 0; i < digits.len(); i++) begin
			if (hex && digits[i] >= "a" && $urandom_range(0, 1))
				add_unit({8'h00, digits[i] - 8'h20}, 1'b0);
			else
				add_unit({8'h00, digits[i]}, 1'b0);
		end
		add_terminator();
	endtask

	task automatic add_name();
		string nm;
		int unsigned k;
		nm = name_text[$urandom_range(0, 4)];
		case ($urandom_range(0, 7))
			0, 1, 2, 3: ;
			4: begin
				k = $urandom_range(0, nm.len() - 1);
				nm[k] = nm[k] - 8'h20;
			end
			5: nm = nm.substr(0, $urandom_range(0, nm.len() - 2));
			6: nm = $sformatf("%s%c", nm, alnum_set[$urandom_range(0, 61)]);
			default: begin
				nm = "";
				repeat ($urandom_range(1, 9))
					nm = $sformatf("%s%c", nm, alnum_set[$urandom_range(0, 61)]);
			end
		endcase
		add_text(nm);
		add_terminator();
	endtask

	// request driver: bursts with random gaps, optional drain before a reference
	always @(posedge clk or negedge arst_n) begin
		char_req_t req;
		bit launch;
		if (!arst_n) begin
			char_valid <= 1'b0;
			code_unit <= 16'h0000;
			first_char <= 1'b0;
		end else begin
			if (char_valid && !char_stall)
				expected_res.push_back(decode_unit(code_unit, first_char));
			if (!(char_valid && char_stall)) begin
				launch = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_chars.size() > 0 &&
						!(pending_chars[0].drain && expected_res.size() > 0)) begin
					req = pending_chars.pop_front();
					code_unit <= req.u;
					first_char <= req.s;
					launch = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						case ($urandom_range(0, 3))
							0: begin
								gap_left = 0;
								burst_left = $urandom_range(20, 60);
							end
							3: begin
								gap_left = $urandom_range(5, 12);
								burst_left = $urandom_range(1, 3);
							end
							default: begin
								gap_left = $urandom_range(1, 4);
								burst_left = $urandom_range(1, 8);
							end
						endcase
					end
				end
				char_valid <= launch;
			end
		end
	end

	// result stall pattern, its rate is redrawn whenever stall_left runs out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
				stall_left = $urandom_range(10, 80);
			end else begin
				stall_left--;
			end
			res_stall <= $urandom_range(0, 99) < stall_pct;
		end
	end

	// result checker
	always @(posedge clk) begin
		hcr_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_res.size() == 0) begin
				$error("result with no request outstanding: unit_first 0x%0h", unit_first);
				error_count++;
			end else begin
				want = expected_res.pop_front();
				check_field("done_res", 16'(want.done), 16'(done_res));
				check_field("consumed", 16'(want.consumed), 16'(consumed));
				check_field("status", 16'(want.status), 16'(status));
				check_field("unit_count", 16'(want.count), 16'(unit_count));
				check_field("unit_first", want.first, unit_first);
				check_field("unit_second", want.second, unit_second);
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clear_parser();

		// directed: zero value, largest code point, name, wrong case,
		// hex with no digits, unit after the end, extreme units
		add_text("#0;");
		add_text("#x10FFFF;");
		add_text("lt;");
		add_text("Gt;");
		add_text("#x;");
		add_unit(16'h0061, 1'b0);
		add_unit(16'hFFFF, 1'b1);
		add_unit(16'h0000, 1'b1);

		// random references, broken forms and noise
		drain_next = 1'b1;
		while (item_total < ITEM_GOAL) begin
			if ($urandom_range(0, 39) == 0)
				drain_next = 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2: add_number(1'b0);
				3, 4, 5: add_number(1'b1);
				6, 7, 8: add_name();
				default: begin
					repeat ($urandom_range(1, 4))
						add_unit(16'($urandom_range(0, 16'hFFFF)),
							1'($urandom_range(0, 1)));
				end
			endcase
			// units past the end of the reference
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 2))
					add_unit(16'($urandom_range(0, 16'hFFFF)), 1'b0);
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_chars.size() > 0 || char_valid)
			@(posedge clk);
		while (expected_res.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_res.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
